>>> rtl/dtq_pkg.sv
package dtq_pkg;

	localparam int CAPACITY  = 32;
	localparam int TIME_BITS = 48;
	localparam int TAG_BITS  = 16;
	localparam int ID_BITS   = 32;
	localparam int ADDR_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_NOW   = 2'd0,
		CMD_AT    = 2'd1,
		CMD_AFTER = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_WAITING  = 3'd0,
		ST_RELEASED = 3'd1,
		ST_FULL     = 3'd2,
		ST_NONE_DUE = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [TIME_BITS-1:0] current_time;
		logic [TIME_BITS-1:0] when_value;
		logic [TAG_BITS-1:0]  task_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [TAG_BITS-1:0]  out_tag;
		logic [ID_BITS-1:0]   task_id;
		logic [TIME_BITS-1:0] out_deadline;
		logic [5:0]           waiting_count;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [ID_BITS-1:0]   id;
		logic [TAG_BITS-1:0]  tag;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UP_RD,
		S_UP_CMP,
		S_TOP_RD,
		S_TOP_CHK,
		S_TAIL_RD,
		S_TAIL_LD,
		S_DN_RD,
		S_DN_L,
		S_DN_CMP,
		S_EMIT
	} state_t;

	function automatic logic entry_before(entry_t a, entry_t b);
		if (a.deadline != b.deadline)
			return a.deadline < b.deadline;
		return a.id < b.id;
	endfunction

endpackage

>>> rtl/deadline_task_queue_core.sv
// Deadline task queue: binary min-heap of pending tasks in one memory with
// a registered read.
// Input channel in_valid/in_ready carries one command (in_item_t). Output
// channel out_valid/out_ready carries results (out_item_t); every command
// gives one result, except a tick that releases several due tasks, one
// result each, earliest deadline first, last set on the final one.
// The block works on one command at a time; in_ready is high only while
// idle, and the next request can be taken in the cycle after the last result leaves.
// An insert climbs the heap level by level until its parent is earlier or it
// reaches the root. A tick on a non-empty queue reads the root; when nothing
// is due or one task is stored it answers without a sift-down, otherwise
// each released task moves the tail to the root and sifts it down, and the
// result is held until the new root shows whether it was the last one.
// A result sits in an output register; while out_ready is low the block
// holds it and continues once it is taken.
// Reset clears the task count and the id counter; the memory is not cleared,
// since only slots that hold stored tasks are ever read.
module deadline_task_queue_core
	import dtq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	entry_t mem [CAPACITY];
	logic [ADDR_BITS-1:0] rd_addr;
	logic                 rd_en, wr_en;
	logic [ADDR_BITS-1:0] wr_addr;
	entry_t               wr_data, rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	state_t state_q, state_d;
	in_item_t req_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [ID_BITS-1:0] id_q;
	entry_t cur_q, lft_q;          // entry being sifted, left child
	logic [ADDR_BITS-1:0] pos_q;
	logic pend_q;                  // res_q holds a release whose last flag is open
	out_item_t res_q;

	logic [TIME_BITS:0] sum;
	logic [TIME_BITS-1:0] dl;
	logic [ID_BITS-1:0] next_id;
	entry_t new_e;
	logic [ADDR_BITS-1:0] up_addr;
	logic [ADDR_BITS:0] l_idx, r_idx;
	logic l_ok, r_ok, root_due, up_stop;
	logic pick_l, pick_r;
	entry_t best_e;
	logic [ADDR_BITS-1:0] best_pos;

	assign sum = {1'b0, req_q.current_time} + {1'b0, req_q.when_value};
	always_comb begin
		unique case (cmd_t'(req_q.command))
			CMD_AT:    dl = req_q.when_value;
			CMD_AFTER: dl = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
			default:   dl = req_q.current_time;
		endcase
	end
	assign next_id  = id_q + ID_BITS'(1);
	assign new_e    = '{deadline: dl, id: next_id, tag: req_q.task_tag};
	assign up_addr  = (pos_q - ADDR_BITS'(1)) >> 1;
	assign l_idx    = {pos_q, 1'b1};
	assign r_idx    = l_idx + (ADDR_BITS+1)'(1);
	assign l_ok     = l_idx < (ADDR_BITS+1)'(cnt_q);
	assign r_ok     = l_ok && (r_idx < (ADDR_BITS+1)'(cnt_q));
	assign root_due = rd_data_s1.deadline <= req_q.current_time;
	assign up_stop  = entry_before(rd_data_s1, cur_q);

	// pick the earliest of the sifted entry and its children
	always_comb begin
		pick_l = entry_before(lft_q, cur_q);
		pick_r = r_ok && entry_before(rd_data_s1, pick_l ? lft_q : cur_q);
		if (pick_r) begin
			best_e = rd_data_s1;
			best_pos = r_idx[ADDR_BITS-1:0];
		end else if (pick_l) begin
			best_e = lft_q;
			best_pos = l_idx[ADDR_BITS-1:0];
		end else begin
			best_e = cur_q;
			best_pos = pos_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign out_data = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (cmd_t'(req_q.command) == CMD_TICK)
					state_d = (cnt_q == '0) ? S_EMIT : S_TOP_RD;
				else if (req_q.task_tag == '0 || dl <= req_q.current_time
					|| cnt_q == CNT_BITS'(CAPACITY))
					state_d = S_EMIT;
				else
					state_d = S_UP_RD;
			end
			S_UP_RD:   state_d = (pos_q == '0) ? S_EMIT : S_UP_CMP;
			S_UP_CMP:  state_d = up_stop ? S_EMIT : S_UP_RD;
			S_TOP_RD:  state_d = S_TOP_CHK;
			S_TOP_CHK: begin
				if (pend_q || !root_due || cnt_q == CNT_BITS'(1))
					state_d = S_EMIT;
				else
					state_d = S_TAIL_RD;
			end
			S_TAIL_RD: state_d = S_TAIL_LD;
			S_TAIL_LD: state_d = S_DN_RD;
			S_DN_RD:   state_d = l_ok ? S_DN_L : S_TOP_RD;
			S_DN_L:    state_d = S_DN_CMP;
			S_DN_CMP:  state_d = (pick_l || pick_r) ? S_DN_RD : S_TOP_RD;
			// root is still in rd_data_s1 when the tick goes on
			S_EMIT:    if (out_ready)
				state_d = res_q.last ? S_IDLE : S_TOP_CHK;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		unique case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = up_addr;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (!up_stop)
					wr_data = rd_data_s1;
			end
			S_TOP_RD: rd_en = 1'b1;
			S_TAIL_RD: begin
				rd_en = 1'b1;
				rd_addr = ADDR_BITS'(cnt_q);
			end
			S_DN_RD: begin
				if (l_ok) begin
					rd_en = 1'b1;
					rd_addr = l_idx[ADDR_BITS-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			S_DN_L: if (r_ok) begin
				rd_en = 1'b1;
				rd_addr = r_idx[ADDR_BITS-1:0];
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				wr_data = best_e;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			cnt_q <= '0;
			id_q <= '0;
			cur_q <= '0;
			lft_q <= '0;
			pos_q <= '0;
			pend_q <= 1'b0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: if (in_valid)
					req_q <= in_data;
				S_DECODE: begin
					if (cmd_t'(req_q.command) == CMD_TICK) begin
						// stands unless the tick releases something
						res_q <= '{status: ST_NONE_DUE, out_tag: '0, task_id: '0,
							out_deadline: '0, waiting_count: 6'(cnt_q), last: 1'b1};
					end else if (req_q.task_tag == '0) begin
						res_q <= '{status: ST_INVALID, out_tag: '0, task_id: '0,
							out_deadline: '0, waiting_count: 6'(cnt_q), last: 1'b1};
					end else if (dl <= req_q.current_time) begin
						id_q <= next_id;
						res_q <= '{status: ST_RELEASED, out_tag: req_q.task_tag,
							task_id: next_id, out_deadline: req_q.current_time,
							waiting_count: 6'(cnt_q), last: 1'b1};
					end else if (cnt_q == CNT_BITS'(CAPACITY)) begin
						id_q <= next_id;
						res_q <= '{status: ST_FULL, out_tag: req_q.task_tag,
							task_id: next_id, out_deadline: dl,
							waiting_count: 6'(cnt_q), last: 1'b1};
					end else begin
						id_q <= next_id;
						cnt_q <= cnt_q + CNT_BITS'(1);
						pos_q <= ADDR_BITS'(cnt_q);
						cur_q <= new_e;
						res_q <= '{status: ST_WAITING, out_tag: req_q.task_tag,
							task_id: next_id, out_deadline: dl,
							waiting_count: 6'(cnt_q + CNT_BITS'(1)), last: 1'b1};
					end
				end
				S_UP_CMP: if (!up_stop)
					pos_q <= up_addr;
				S_TOP_CHK: begin
					if (pend_q) begin
						// new root decides whether the held release is final
						res_q.last <= !root_due;
						pend_q <= 1'b0;
					end else if (root_due) begin
						res_q <= '{status: ST_RELEASED, out_tag: rd_data_s1.tag,
							task_id: rd_data_s1.id, out_deadline: rd_data_s1.deadline,
							waiting_count: 6'(cnt_q - CNT_BITS'(1)),
							last: (cnt_q == CNT_BITS'(1))};
						cnt_q <= cnt_q - CNT_BITS'(1);
						pend_q <= (cnt_q != CNT_BITS'(1));
						pos_q <= '0;
					end
				end
				S_TAIL_LD: cur_q <= rd_data_s1;
				S_DN_L:    lft_q <= rd_data_s1;
				S_DN_CMP:  pos_q <= best_pos;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_BITS'(CAPACITY))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DECODE) else $error("no decode");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en && rd_addr == wr_addr)) else $error("read and write collide");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while result waits");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import dtq_pkg::*;

	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
	localparam int LIMIT = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	deadline_task_queue_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// shadow of the timer heap, kept as a flat list
	entry_t    pend_list[$];
	logic [31:0] id_ctr;
	out_item_t exp_results[$];
	int        errors = 0;
	int        n_results = 0;
	int        n_released = 0;
	int        n_full = 0;
	int        n_sent = 0;
	bit        no_idle = 1'b0;
	longint    cycles = 0;

	function automatic bit earlier(entry_t a, entry_t b);
		if (a.deadline != b.deadline)
			return a.deadline < b.deadline;
		return a.id < b.id;
	endfunction

	function automatic out_item_t mk(status_t st, logic [TAG_BITS-1:0] tg,
		logic [31:0] id, logic [TIME_BITS-1:0] dl, bit fin);
		out_item_t r;
		r.status = st;
		r.out_tag = tg;
		r.task_id = id;
		r.out_deadline = dl;
		r.waiting_count = 6'(pend_list.size());
		r.last = fin;
		return r;
	endfunction

	task automatic predict_queue(in_item_t it);
		logic [TIME_BITS:0] sum;
		logic [TIME_BITS-1:0] dl;
		entry_t e;
		int b;
		if (cmd_t'(it.command) == CMD_TICK) begin
			int n;
			n = 0;
			forever begin
				if (pend_list.size() == 0)
					break;
				b = 0;
				foreach (pend_list[i])
					if (earlier(pend_list[i], pend_list[b]))
						b = i;
				if (pend_list[b].deadline > it.current_time)
					break;
				e = pend_list[b];
				pend_list.delete(b);
				b = 0;
				foreach (pend_list[i])
					if (earlier(pend_list[i], pend_list[b]))
						b = i;
				exp_results.push_back(mk(ST_RELEASED, e.tag, e.id, e.deadline,
					pend_list.size() == 0 || pend_list[b].deadline > it.current_time));
				n++;
			end
			if (n == 0)
				exp_results.push_back(mk(ST_NONE_DUE, '0, '0, '0, 1'b1));
			return;
		end
		if (it.task_tag == '0) begin
			exp_results.push_back(mk(ST_INVALID, '0, '0, '0, 1'b1));
			return;
		end
		case (cmd_t'(it.command))
			CMD_NOW: dl = it.current_time;
			CMD_AT:  dl = it.when_value;
			default: begin
				sum = {1'b0, it.current_time} + {1'b0, it.when_value};
				dl = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
			end
		endcase
		id_ctr++;
		if (dl <= it.current_time)
			exp_results.push_back(mk(ST_RELEASED, it.task_tag, id_ctr,
				it.current_time, 1'b1));
		else if (pend_list.size() >= CAPACITY)
			exp_results.push_back(mk(ST_FULL, it.task_tag, id_ctr, dl, 1'b1));
		else begin
			e.deadline = dl;
			e.id = id_ctr;
			e.tag = it.task_tag;
			pend_list.push_back(e);
			exp_results.push_back(mk(ST_WAITING, it.task_tag, id_ctr, dl, 1'b1));
		end
	endtask

	// valid stays high across back-to-back requests; drop it only to idle
	task automatic send_request(in_item_t it);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_queue(it);
		n_sent++;
	endtask

	// result side: random stall bursts
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				out_item_t ex;
				n_results++;
				if (exp_results.size() == 0) begin
					$error("unexpected result status=%0d", out_data.status);
					errors++;
				end else begin
					ex = exp_results.pop_front();
					if (out_data.status == ST_RELEASED)
						n_released++;
					if (out_data.status == ST_FULL)
						n_full++;
					if (out_data.status !== ex.status) begin
						$error("status exp %0d got %0d", ex.status, out_data.status);
						errors++;
					end
					if (out_data.out_tag !== ex.out_tag) begin
						$error("out_tag exp %0h got %0h", ex.out_tag, out_data.out_tag);
						errors++;
					end
					if (out_data.task_id !== ex.task_id) begin
						$error("task_id exp %0d got %0d", ex.task_id, out_data.task_id);
						errors++;
					end
					if (out_data.out_deadline !== ex.out_deadline) begin
						$error("out_deadline exp %0h got %0h", ex.out_deadline,
							out_data.out_deadline);
						errors++;
					end
					if (out_data.waiting_count !== ex.waiting_count) begin
						$error("waiting_count exp %0d got %0d", ex.waiting_count,
							out_data.waiting_count);
						errors++;
					end
					if (out_data.last !== ex.last) begin
						$error("last exp %0d got %0d", ex.last, out_data.last);
						errors++;
					end
				end
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout with %0d results outstanding", exp_results.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic in_item_t req(cmd_t c, logic [TIME_BITS-1:0] t,
		logic [TIME_BITS-1:0] w, logic [TAG_BITS-1:0] g);
		in_item_t r;
		r.command = c;
		r.current_time = t;
		r.when_value = w;
		r.task_tag = g;
		return r;
	endfunction

	function automatic logic [TIME_BITS-1:0] rand_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// directed rows; check rows swap the predicted result for a fixed one
	typedef struct {
		in_item_t it;
		bit       check;
		out_item_t fixed;
	} row_t;

	initial begin
		row_t rows[$];
		logic [TIME_BITS-1:0] now;
		in_item_t it;
		int k;
		id_ctr = '0;
		rows.push_back('{req(CMD_TICK, '0, '0, '0), 1,
			'{ST_NONE_DUE, 16'd0, 32'd0, 48'd0, 6'd0, 1'b1}});
		rows.push_back('{req(CMD_NOW, TMAX, TMAX, 16'hffff), 1,
			'{ST_RELEASED, 16'hffff, 32'd1, TMAX, 6'd0, 1'b1}});
		rows.push_back('{req(CMD_AT, 48'd5, 48'd9, 16'h0000), 1,
			'{ST_INVALID, 16'd0, 32'd0, 48'd0, 6'd0, 1'b1}});
		rows.push_back('{req(CMD_AT, 48'd100, 48'd50, 16'h0001), 1,
			'{ST_RELEASED, 16'h0001, 32'd2, 48'd100, 6'd0, 1'b1}});
		rows.push_back('{req(CMD_AT, 48'd100, 48'd100, 16'h0002), 1,
			'{ST_RELEASED, 16'h0002, 32'd3, 48'd100, 6'd0, 1'b1}});
		rows.push_back('{req(CMD_AFTER, 48'd10, 48'd0, 16'h0003), 1,
			'{ST_RELEASED, 16'h0003, 32'd4, 48'd10, 6'd0, 1'b1}});
		rows.push_back('{req(CMD_AFTER, TMAX - 1, TMAX, 16'h8000), 1,
			'{ST_WAITING, 16'h8000, 32'd5, TMAX, 6'd1, 1'b1}});
		rows.push_back('{req(CMD_AT, 48'd0, 48'd1, 16'h1234), 0, '0});
		rows.push_back('{req(CMD_AFTER, 48'd0, 48'd1, 16'h5678), 0, '0});
		rows.push_back('{req(CMD_AT, 48'd0, 48'd20, 16'h00aa), 0, '0});
		rows.push_back('{req(CMD_TICK, 48'd1, 48'd7, 16'h7777), 0, '0});
		rows.push_back('{req(CMD_TICK, TMAX, '0, '0), 0, '0});
		rows.push_back('{req(CMD_TICK, TMAX, '0, '0), 1,
			'{ST_NONE_DUE, 16'd0, 32'd0, 48'd0, 6'd0, 1'b1}});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_request(rows[i].it);
			if (rows[i].check)
				exp_results[exp_results.size()-1] = rows[i].fixed;
		end
		// fill past capacity with three repeated deadlines to exercise id order and full
		for (k = 0; k < CAPACITY + 3; k++)
			send_request(req(CMD_AT, 48'd1000, 48'd2000 + (k % 3), 16'(k + 1)));
		send_request(req(CMD_TICK, 48'd5000, '0, '0));
		// random part: a slowly advancing clock with bursts of schedules
		now = 48'd3000;
		for (k = 0; k < 70; k++) begin
			if (k >= 55)
				no_idle = 1'b1;
			now = now + $urandom_range(0, 40);
			case ($urandom_range(0, 9))
				0: it = req(CMD_NOW, now, rand_time(), 16'($urandom));
				1, 2: it = req(CMD_AT, now, now + $urandom_range(0, 200),
					16'($urandom));
				3: it = req(CMD_AT, rand_time(), rand_time(), 16'($urandom));
				4, 5: it = req(CMD_AFTER, now, $urandom_range(0, 200),
					16'($urandom));
				6: it = req(CMD_AFTER, rand_time(), rand_time(),
					$urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom));
				default: it = req(CMD_TICK, now, rand_time(), 16'($urandom));
			endcase
			send_request(it);
		end
		send_request(req(CMD_TICK, TMAX, '0, '0));
		in_valid <= 1'b0;
		while (exp_results.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d requests driven, %0d results checked", n_sent, n_results);
		$display("%0d released, %0d rejected as full", n_released, n_full);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
